// ----- rtl/ptfm_pkg.sv -----
// shared constants and types of the perspective floor texel mapper
package ptfm_pkg;

  localparam int TEX_SIDE    = 64;
  localparam int TEX_BITS    = 6;
  localparam int ADDR_BITS   = 12;
  localparam int SCREEN_W    = 640;
  localparam int SCREEN_H    = 400;
  localparam int TILE_BITS   = 13;   // tile of 32 units in Q.8
  localparam int DEPTH_BITS  = 31;

  typedef enum logic [2:0] {
    REG_CAM_X      = 3'd0,
    REG_CAM_Y      = 3'd1,
    REG_ROT_COS    = 3'd2,
    REG_ROT_SIN    = 3'd3,
    REG_FOCAL_LEN  = 3'd4,
    REG_Y_SCALE    = 3'd5,
    REG_TEX_WIDTH  = 3'd6,
    REG_TEX_HEIGHT = 3'd7
  } cfg_reg_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SHADE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  col;
    logic [8:0]  row;
    logic [11:0] idx;
    logic [31:0] color;
    logic        deg;
    logic        nneg;
    logic [10:0] nabs;
  } pay_t;

endpackage

// ----- rtl/ptfm_div.sv -----
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module ptfm_div #(
  parameter int NW = 42,
  parameter int DW = 10,
  parameter int QW = 31,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic          v_r    [0:QW];
  logic [DW-1:0] rem_r  [0:QW];
  logic [QW-1:0] low_r  [0:QW];
  logic [QW-1:0] q_r    [0:QW];
  logic [DW-1:0] den_r  [0:QW];
  logic          sat_r  [0:QW];
  logic [SW-1:0] side_r [0:QW];

  logic [NW-1:0] hi;
  logic          sat_nxt;

  assign hi      = num >> QW;
  assign sat_nxt = hi >= NW'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      rem_r[0]  <= hi[DW-1:0];
      low_r[0]  <= num[QW-1:0];
      q_r[0]    <= '0;
      den_r[0]  <= den;
      sat_r[0]  <= sat_nxt;
      side_r[0] <= side;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[i-1], low_r[i-1][QW-1]};
      ge      = trial >= {1'b0, den_r[i-1]};
      rem_nxt = ge ? DW'(trial - {1'b0, den_r[i-1]}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
      if (en) begin
        rem_r[i]  <= rem_nxt;
        low_r[i]  <= low_r[i-1] << 1;
        q_r[i]    <= {q_r[i-1][QW-2:0], ge};
        den_r[i]  <= den_r[i-1];
        sat_r[i]  <= sat_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign quo       = sat_r[QW] ? '1 : q_r[QW];
  assign out_side  = side_r[QW];

endmodule

// ----- rtl/perspective_floor_texel_mapper.sv -----
// Maps floor and ceiling pixels to texels of a 64x64 store: one request per clock while
// the output is not stalled, fully pipelined. A request passes 9 arithmetic stages
// and two 32-stage dividers, one for depth and one for the lateral offset.
// A stall on the output freezes the whole pipeline. Load requests travel the same
// pipeline and write the texture store at the stage where shade requests read it,
// so loads and shades keep their order. Loads produce no result.
module perspective_floor_texel_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command
  input  logic        in_tuser,
  // col, row, plane_height, texel_index, texel_color, zero pad
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // degenerate
  output logic        out_tuser,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import ptfm_pkg::*;

  logic               en;
  logic signed [31:0] cam_x_r, cam_y_r;
  logic signed [15:0] rot_cos_r, rot_sin_r;
  logic [15:0]        focal_r, yscale_r;
  logic [6:0]         tw_r, th_r;
  logic [20:0]        k_r;
  logic [25:0]        den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      rot_cos_r <= 16'sd16384;
      rot_sin_r <= '0;
      focal_r   <= 16'd4096;
      yscale_r  <= 16'd6554;
      tw_r      <= 7'd64;
      th_r      <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CAM_X:      cam_x_r   <= cfg_wdata;
        REG_CAM_Y:      cam_y_r   <= cfg_wdata;
        REG_ROT_COS:    rot_cos_r <= cfg_wdata[15:0];
        REG_ROT_SIN:    rot_sin_r <= cfg_wdata[15:0];
        REG_FOCAL_LEN:  focal_r   <= cfg_wdata[15:0];
        REG_Y_SCALE:    yscale_r  <= cfg_wdata[15:0];
        REG_TEX_WIDTH:  tw_r      <= cfg_wdata[6:0];
        REG_TEX_HEIGHT: th_r      <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // derived constants follow the registers in the next cycle
  always_ff @(posedge clk) begin
    k_r    <= 21'((32'(focal_r) * 32'(yscale_r)) >> 12);
    den2_r <= 26'(26'(focal_r) * 26'(SCREEN_W));
  end

  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // stage 1: unpack, signs and magnitudes
  logic signed [23:0] ph;
  logic signed [11:0] d_s, nxn_s;
  pay_t               pay1_nxt;
  logic               v1_r, phneg1_r;
  logic [23:0]        phabs1_r;
  logic [9:0]         dabs1_r;
  logic               dneg1_r, phz1_r;
  pay_t               pay1_r;

  always_comb begin
    ph    = in_tdata[42:19];
    d_s   = 12'(SCREEN_H + 1) - {2'b0, in_tdata[18:10], 1'b0};
    nxn_s = {1'b0, in_tdata[9:0], 1'b1} - 12'(SCREEN_W);
    pay1_nxt.cmd   = in_tuser;
    pay1_nxt.col   = in_tdata[9:0];
    pay1_nxt.row   = in_tdata[18:10];
    pay1_nxt.idx   = in_tdata[54:43];
    pay1_nxt.color = in_tdata[86:55];
    pay1_nxt.deg   = 1'b0;
    pay1_nxt.nneg  = nxn_s[11];
    pay1_nxt.nabs  = nxn_s[11] ? 11'(-nxn_s) : nxn_s[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
    if (en) begin
      pay1_r   <= pay1_nxt;
      phneg1_r <= ph[23];
      phz1_r   <= ph == '0;
      phabs1_r <= ph[23] ? 24'(-ph) : ph;
      dneg1_r  <= d_s[11];
      dabs1_r  <= d_s[11] ? 10'(-d_s) : d_s[9:0];
    end
  end

  // stage 2: |ph| * k
  logic        v2_r;
  logic [44:0] p1_r;
  logic [9:0]  dabs2_r;
  pay_t        pay2_r, pay2_nxt;
  always_comb begin
    pay2_nxt     = pay1_r;
    pay2_nxt.deg = phz1_r || dabs1_r == '0 || (phneg1_r != dneg1_r) || k_r == '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      p1_r    <= 45'(phabs1_r) * 45'(k_r);
      dabs2_r <= dabs1_r;
      pay2_r  <= pay2_nxt;
    end
  end

  // stage 3: times screen height
  logic        v3_r;
  logic [53:0] p2_r;
  logic [9:0]  dabs3_r;
  pay_t        pay3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      p2_r    <= 54'(p1_r) * 54'(SCREEN_H);
      dabs3_r <= dabs2_r;
      pay3_r  <= pay2_r;
    end
  end

  // depth divider: (num >> 12) / |d| equals num / (|d| << 12)
  logic                  dv1_valid;
  logic [DEPTH_BITS-1:0] depth_q;
  logic [$bits(pay_t)-1:0] dv1_side;

  ptfm_div #(.NW(42), .DW(10), .QW(DEPTH_BITS), .SW($bits(pay_t))) u_div_depth (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_r),
    .num(p2_r[53:12]), .den(dabs3_r), .side(pay3_r),
    .out_valid(dv1_valid), .quo(depth_q), .out_side(dv1_side)
  );

  // stage 4: |nxn| * depth
  logic                  v4_r;
  logic [41:0]           p3_r;
  logic [DEPTH_BITS-1:0] depth4_r;
  pay_t                  pay4_r, pay4_nxt;
  always_comb begin
    pay4_nxt     = pay_t'(dv1_side);
    pay4_nxt.deg = pay4_nxt.deg || depth_q == '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= dv1_valid;
    if (en) begin
      p3_r     <= 42'(pay4_nxt.nabs) * 42'(depth_q);
      depth4_r <= depth_q;
      pay4_r   <= pay4_nxt;
    end
  end

  // lateral offset divider
  localparam int S2W = $bits(pay_t) + DEPTH_BITS;
  logic                  dv2_valid;
  logic [DEPTH_BITS-1:0] mag_q;
  logic [S2W-1:0]        dv2_side;

  ptfm_div #(.NW(54), .DW(26), .QW(DEPTH_BITS), .SW(S2W)) u_div_lat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r),
    .num({p3_r, 12'b0}), .den(den2_r), .side({pay4_r, depth4_r}),
    .out_valid(dv2_valid), .quo(mag_q), .out_side(dv2_side)
  );

  // stage 5: rotation products
  pay_t               pay5_nxt, pay5_r;
  logic signed [31:0] vx, vy;
  logic               v5_r;
  logic signed [47:0] xc_r, ys_r, xs_r, yc_r;
  always_comb begin
    pay5_nxt = pay_t'(dv2_side[S2W-1:DEPTH_BITS]);
    vy       = {1'b0, dv2_side[DEPTH_BITS-1:0]};
    vx       = pay5_nxt.nneg ? -{1'b0, mag_q} : {1'b0, mag_q};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= dv2_valid;
    if (en) begin
      xc_r   <= vx * rot_cos_r;
      ys_r   <= vy * rot_sin_r;
      xs_r   <= vx * rot_sin_r;
      yc_r   <= vy * rot_cos_r;
      pay5_r <= pay5_nxt;
    end
  end

  // stage 6: sums, floor shift, camera offset, tile wrap (low bits only)
  logic signed [48:0] sx, sy;
  logic signed [48:0] fx, fy;
  logic               v6_r;
  logic [TILE_BITS-1:0] mx6_r, my6_r;
  pay_t               pay6_r;
  always_comb begin
    sx = 49'(xc_r) - 49'(ys_r);
    sy = 49'(xs_r) + 49'(yc_r);
    fx = sx >>> 14;
    fy = sy >>> 14;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      mx6_r  <= fx[TILE_BITS-1:0] + cam_x_r[TILE_BITS-1:0];
      my6_r  <= fy[TILE_BITS-1:0] + cam_y_r[TILE_BITS-1:0];
      pay6_r <= pay5_r;
    end
  end

  // stage 7: texel coordinates, border test, store address
  logic [19:0]          txw, tyw;
  logic [6:0]           tx, ty;
  logic                 border;
  logic                 v7_r, black7_r;
  logic [ADDR_BITS-1:0] addr7_r;
  pay_t                 pay7_r;
  always_comb begin
    txw = (20'(mx6_r) * 20'(tw_r)) >> TILE_BITS;
    tyw = (20'(my6_r) * 20'(th_r)) >> TILE_BITS;
    tx  = (tw_r == '0) ? 7'd0 : (txw >= 20'(tw_r)) ? 7'(tw_r - 7'd1) : txw[6:0];
    ty  = (th_r == '0) ? 7'd0 : (tyw >= 20'(th_r)) ? 7'(th_r - 7'd1) : tyw[6:0];
    border = tx == '0 || ty == '0 || 7'(tx + 7'd1) == tw_r || 7'(ty + 7'd1) == th_r ||
             tw_r == '0 || th_r == '0 || tx >= 7'(TEX_SIDE) || ty >= 7'(TEX_SIDE);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
    if (en) begin
      black7_r <= border || pay6_r.deg;
      addr7_r  <= (pay6_r.cmd == CMD_LOAD) ? pay6_r.idx
                                           : {ty[TEX_BITS-1:0], tx[TEX_BITS-1:0]};
      pay7_r   <= pay6_r;
    end
  end

  // stage 8: texture store, one access per cycle while the pipeline advances
  logic [31:0] mem [0:TEX_SIDE*TEX_SIDE-1];
  logic [31:0] rdata8_r;
  logic        v8_r, black8_r;
  pay_t        pay8_r;
  always_ff @(posedge clk) begin
    if (en && v7_r) begin
      if (pay7_r.cmd == CMD_LOAD) mem[addr7_r] <= pay7_r.color;
      rdata8_r <= mem[addr7_r];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r && pay7_r.cmd == CMD_SHADE;
    if (en) begin
      black8_r <= black7_r;
      pay8_r   <= pay7_r;
    end
  end

  // stage 9: output register
  logic [9:0]  px_r;
  logic [8:0]  py_r;
  logic [31:0] pc_r;
  logic        deg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v8_r;
    if (en) begin
      px_r  <= pay8_r.col;
      py_r  <= pay8_r.row;
      pc_r  <= black8_r ? 32'd0 : rdata8_r;
      deg_r <= pay8_r.deg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = deg_r;
  assign out_tdata  = {5'b0, pc_r, py_r, px_r};

`ifndef SYNTH
  a_deg_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[50:19] == 32'd0)
    else $error("degenerate pixel with nonzero color");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("pipeline advanced during output stall");
`endif

endmodule

// ----- verif/tb_perspective_floor_texel_mapper.sv -----
// self-checking testbench of the perspective floor texel mapper
`timescale 1ns / 1ps

module tb_perspective_floor_texel_mapper;
  import ptfm_pkg::*;

  typedef struct {
    logic        cmd;
    logic [9:0]  col;
    logic [8:0]  row;
    logic [23:0] ph;
    logic [11:0] idx;
    logic [31:0] color;
  } req_t;

  typedef struct {
    logic [9:0]  px;
    logic [8:0]  py;
    logic [31:0] color;
    logic        deg;
  } pix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tuser = 1'b0;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tuser;
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  perspective_floor_texel_mapper u_dut (.*);

  always #2 clk = ~clk;

  req_t pend_q[$];
  pix_t pixel_q[$];
  logic [31:0] tex_mem [TEX_SIDE*TEX_SIDE];
  bit          tex_written [TEX_SIDE*TEX_SIDE];
  longint      m_cam_x = 0, m_cam_y = 0, m_cos = 16384, m_sin = 0;
  longint      m_focal = 4096, m_yscale = 6554, m_tw = 64, m_th = 64;
  int          n_err = 0, n_load = 0, n_shade = 0, n_deg = 0, n_black = 0, n_cfg = 0;
  logic        in_fire = 1'b0;
  int          gap_cnt = 0, burst_cnt = 8, stall_cnt = 0, run_cnt = 20;
  int          idle_cycles = 0;

  task automatic write_cfg(cfg_reg_t r, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    n_cfg++;
    case (r)
      REG_CAM_X:      m_cam_x = longint'($signed(v));
      REG_CAM_Y:      m_cam_y = longint'($signed(v));
      REG_ROT_COS:    m_cos = longint'($signed(v[15:0]));
      REG_ROT_SIN:    m_sin = longint'($signed(v[15:0]));
      REG_FOCAL_LEN:  m_focal = v[15:0];
      REG_Y_SCALE:    m_yscale = v[15:0];
      REG_TEX_WIDTH:  m_tw = v[6:0];
      REG_TEX_HEIGHT: m_th = v[6:0];
      default: ;
    endcase
  endtask

  function automatic longint wrap_texel(longint w, longint size);
    longint t;
    t = ((w & 8191) * size) >>> TILE_BITS;
    if (size == 0) return 0;
    if (t > size - 1) t = size - 1;
    return t;
  endfunction

  // computes the pixel for a shade; reads tells whether the store is looked up at addr
  function automatic pix_t map_pixel(req_t r, output bit reads, output int addr);
    pix_t   p;
    longint ph, d, k, depth, nxn, mag, vx, wx, wy, tx, ty;
    bit     deg;
    p.px = r.col;
    p.py = r.row;
    p.color = '0;
    reads = 0;
    addr = 0;
    ph = longint'($signed(r.ph));
    d = SCREEN_H + 1 - 2 * longint'(r.row);
    k = (m_focal * m_yscale) >>> 12;
    depth = 0;
    deg = (ph == 0) || (d == 0) || ((ph < 0) != (d < 0)) || (k == 0);
    if (!deg) begin
      depth = ((ph < 0 ? -ph : ph) * k * SCREEN_H) / ((d < 0 ? -d : d) <<< 12);
      if (depth == 0) deg = 1;
    end
    p.deg = deg;
    if (deg) return p;
    if (depth > 64'h7FFF_FFFF) depth = 64'h7FFF_FFFF;
    nxn = 2 * longint'(r.col) + 1 - SCREEN_W;
    mag = ((nxn < 0 ? -nxn : nxn) * 4096 * depth) / (SCREEN_W * m_focal);
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    vx = nxn < 0 ? -mag : mag;
    wx = ((vx * m_cos - depth * m_sin) >>> 14) + m_cam_x;
    wy = ((vx * m_sin + depth * m_cos) >>> 14) + m_cam_y;
    tx = wrap_texel(wx, m_tw);
    ty = wrap_texel(wy, m_th);
    if (!(tx == 0 || ty == 0 || tx + 1 == m_tw || ty + 1 == m_th || m_tw == 0 || m_th == 0)
        && tx < TEX_SIDE && ty < TEX_SIDE) begin
      reads = 1;
      addr = int'(ty * TEX_SIDE + tx);
    end
    return p;
  endfunction

  task automatic push_load(logic [11:0] idx, logic [31:0] color);
    req_t r;
    r = '{CMD_LOAD, 10'($urandom), 9'($urandom), 24'($urandom), idx, color};
    pend_q.push_back(r);
    tex_mem[idx] = color;
    tex_written[idx] = 1;
    n_load++;
  endtask

  task automatic push_shade(logic [9:0] col, logic [8:0] row, logic [23:0] ph);
    req_t r;
    pix_t p;
    bit   reads;
    int   addr;
    r = '{CMD_SHADE, col, row, ph, 12'($urandom), $urandom};
    p = map_pixel(r, reads, addr);
    // never look up an unwritten entry: load it just ahead of the shade
    if (reads && !tex_written[addr]) push_load(addr[11:0], $urandom);
    if (reads) p.color = tex_mem[addr];
    pend_q.push_back(r);
    pixel_q.push_back(p);
    n_shade++;
    if (p.deg) n_deg++;
    else if (p.color == 0) n_black++;
  endtask

  task automatic wait_idle();
    wait (pend_q.size() == 0 && pixel_q.size() == 0 && !in_tvalid);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_shades(int n);
    logic [8:0]  row;
    logic [23:0] ph;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        push_load(12'($urandom), $urandom);
      end else begin
        row = 9'($urandom);
        case ($urandom_range(0, 3))
          0: ph = 24'($urandom);
          1: ph = 24'($urandom_range(1, 4096));
          default: ph = 24'($urandom_range(256, 65536));
        endcase
        // mostly put the plane on the side of the horizon that the row sees
        if ($urandom_range(0, 4) != 0 && ((row > 200) != ph[23])) ph = -ph;
        push_shade(10'($urandom), row, ph);
      end
    end
  endtask

  task automatic set_view(logic [31:0] cx, logic [31:0] cy, logic [15:0] c, logic [15:0] s,
                          logic [15:0] f, logic [15:0] ys, logic [6:0] tw, logic [6:0] th);
    write_cfg(REG_CAM_X, cx);
    write_cfg(REG_CAM_Y, cy);
    write_cfg(REG_ROT_COS, {{16{c[15]}}, c});
    write_cfg(REG_ROT_SIN, {{16{s[15]}}, s});
    write_cfg(REG_FOCAL_LEN, {16'b0, f});
    write_cfg(REG_Y_SCALE, {16'b0, ys});
    write_cfg(REG_TEX_WIDTH, {25'b0, tw});
    write_cfg(REG_TEX_HEIGHT, {25'b0, th});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ang;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: reset view, field extremes and each corner case
    push_load(12'd0, 32'hFFFF_FFFF);
    push_load(12'd4095, 32'h0000_0001);
    push_shade(10'd0, 9'd0, 24'h7F_FFFF);
    push_shade(10'd639, 9'd399, 24'h80_0000);
    push_shade(10'd1023, 9'd511, 24'hFF_FF00);
    push_shade(10'd320, 9'd200, 24'h00_0100);
    push_shade(10'd319, 9'd201, 24'hFF_FF00);
    push_shade(10'd100, 9'd100, 24'h00_0000);
    push_shade(10'd100, 9'd100, 24'hFF_F000);
    push_shade(10'd100, 9'd300, 24'h00_1000);
    push_shade(10'd10, 9'd0, 24'h00_0001);
    push_shade(10'd500, 9'd150, 24'h00_0800);
    push_shade(10'd200, 9'd350, 24'hFF_F800);
    push_shade(10'd1000, 9'd450, 24'hFF_0000);
    push_shade(10'd600, 9'd20, 24'h01_0000);
    wait_idle();
    set_view(32'h8000_0000, 32'h7FFF_FFFF, -16'sd16384, 16'sd16384, 16'd1, 16'd65535,
             7'd2, 7'd64);
    random_shades(200);
    wait_idle();
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 16'sd16384, -16'sd16384, 16'd65535, 16'd1,
             7'd64, 7'd2);
    random_shades(200);
    wait_idle();
    // focal and scale product truncates to zero: every pixel degenerate
    set_view(32'd0, 32'd0, 16'sd0, 16'sd16384, 16'd1, 16'd1, 7'd3, 7'd3);
    random_shades(60);
    wait_idle();
    repeat (5) begin
      ang = $urandom_range(0, 16384);
      set_view($urandom, $urandom, 16'($urandom_range(0, 1) ? ang : -ang),
               16'($urandom_range(0, 1) ? 16384 - ang : ang - 16384),
               16'($urandom_range(1024, 16384)), 16'($urandom_range(2048, 12000)),
               7'($urandom_range(2, 64)), 7'($urandom_range(2, 64)));
      random_shades(240);
      wait_idle();
    end
    $display("covered %0d loads and %0d shades (%0d degenerate, %0d black) over %0d writes",
             n_load, n_shade, n_deg, n_black, n_cfg);
    if (n_err == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // request driver: bursts with random gaps
  always @(negedge clk) begin
    if (!in_tvalid || in_fire) begin
      if (rst_n && gap_cnt == 0 && pend_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= pend_q[0].cmd;
        in_tdata <= {1'b0, pend_q[0].color, pend_q[0].idx, pend_q[0].ph,
                     pend_q[0].row, pend_q[0].col};
        void'(pend_q.pop_front());
        if (burst_cnt <= 1) begin
          burst_cnt = $urandom_range(1, 40);
          gap_cnt = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
        end else begin
          burst_cnt--;
        end
      end else begin
        in_tvalid <= 1'b0;
        if (gap_cnt > 0) gap_cnt--;
      end
    end
    // receiver: runs of readiness broken by stalls of random length
    if (stall_cnt > 0) begin
      out_tready <= 1'b0;
      stall_cnt--;
    end else begin
      out_tready <= 1'b1;
      if (run_cnt <= 0) begin
        run_cnt = $urandom_range(0, 60);
        stall_cnt = $urandom_range(1, 12);
      end else begin
        run_cnt--;
      end
    end
  end

  always @(posedge clk) begin
    pix_t want;
    in_fire <= in_tvalid && in_tready;
    if (out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $error("result with nothing expected: x %0d y %0d", out_tdata[9:0], out_tdata[18:10]);
        n_err++;
      end else begin
        want = pixel_q.pop_front();
        if (out_tdata[9:0] !== want.px) begin
          $error("pixel_x expected %0d got %0d", want.px, out_tdata[9:0]);
          n_err++;
        end
        if (out_tdata[18:10] !== want.py) begin
          $error("pixel_y expected %0d got %0d", want.py, out_tdata[18:10]);
          n_err++;
        end
        if (out_tdata[50:19] !== want.color) begin
          $error("pixel_color expected %h got %h", want.color, out_tdata[50:19]);
          n_err++;
        end
        if (out_tuser !== want.deg) begin
          $error("degenerate expected %0d got %0d", want.deg, out_tuser);
          n_err++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pixel_q.size() == 0 && pend_q.size() == 0 && !in_tvalid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("watchdog: no progress with %0d results outstanding", pixel_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
